// ----- rtl/core/cpu_trap_and_interrupt_entry_macros.svh -----
// Assertion macros for the trap and interrupt entry block.
// No dependencies; included by the files that carry assertions.
`ifndef CPU_TRAP_AND_INTERRUPT_ENTRY_MACROS_SVH
`define CPU_TRAP_AND_INTERRUPT_ENTRY_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TRAPENT_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("trap entry assertion failed");

// next-cycle implication
`define TRAPENT_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("trap entry assertion failed");

`else

`define TRAPENT_ASSERT_IMPLIES(label, clk, rst, a, b)
`define TRAPENT_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

// ----- rtl/core/trapent_pkg.sv -----
// Shared constants of the trap and interrupt entry block.
// Used by the channel interfaces and the top level; no dependencies.
package trapent_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ADDR_W = 4;

  localparam logic [OP_W-1:0] OP_INTERRUPT = 2'd0;
  localparam logic [OP_W-1:0] OP_EXCEPTION = 2'd1;
  localparam logic [OP_W-1:0] OP_PSW_WRITE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_IGNORED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REDIRECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FATAL    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PSW      = 2'd3;

  // status word bit positions
  localparam int unsigned PSW_ID = 12;
  localparam int unsigned PSW_AE = 13;
  localparam int unsigned PSW_EP = 14;
  localparam int unsigned PSW_NP = 15;
  localparam int unsigned PSW_I_LO = 16;
  localparam int unsigned PSW_I_HI = 19;

  localparam logic [WORD_W-1:0] PSW_RESET     = 32'h0000_8000;
  localparam logic [WORD_W-1:0] VEC_INTERRUPT = 32'hFFFF_FE00;
  localparam logic [WORD_W-1:0] VEC_DUPLEXED  = 32'hFFFF_FFD0;
  localparam logic [WORD_W-1:0] VEC_EXCEPTION = 32'hFFFF_FF80;
  localparam logic [WORD_W-1:0] FATAL_TAG     = 32'hFFFF_0000;

  localparam logic [ADDR_W-1:0] DUMP_ADDR_CODE = 4'h0;
  localparam logic [ADDR_W-1:0] DUMP_ADDR_PSW  = 4'h4;
  localparam logic [ADDR_W-1:0] DUMP_ADDR_PC   = 4'h8;

endpackage

// ----- rtl/core/trapent_if.sv -----
// Valid/ready channel interfaces of the trap and interrupt entry block.
// Depends on trapent_pkg for field widths.
interface trapent_req_if import trapent_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CODE_W-1:0] code;
  logic [WORD_W-1:0] pc;
  logic [WORD_W-1:0] psw_value;

  modport source (output valid, operation, code, pc, psw_value, input ready);
  modport sink   (input valid, operation, code, pc, psw_value, output ready);
endinterface

interface trapent_rsp_if import trapent_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [WORD_W-1:0] new_pc;
  logic [ADDR_W-1:0] store_addr;
  logic [WORD_W-1:0] store_data;
  logic              last;
  logic [WORD_W-1:0] psw_now;
  logic [WORD_W-1:0] eipc_now;
  logic [WORD_W-1:0] eipsw_now;
  logic [WORD_W-1:0] fepc_now;
  logic [WORD_W-1:0] fepsw_now;
  logic [WORD_W-1:0] ecr_now;

  modport source (output valid, kind, new_pc, store_addr, store_data, last, psw_now,
                  eipc_now, eipsw_now, fepc_now, fepsw_now, ecr_now, input ready);
  modport sink   (input valid, kind, new_pc, store_addr, store_data, last, psw_now,
                  eipc_now, eipsw_now, fepc_now, fepsw_now, ecr_now, output ready);
endinterface

// ----- rtl/core/cpu_trap_and_interrupt_entry.sv -----
// Top level of the trap and interrupt entry block: status word, save
// registers, event decode and result register. Depends on trapent_pkg,
// trapent_if.sv and cpu_trap_and_interrupt_entry_macros.svh.

// One event (interrupt request, exception or status word write) is taken per
// cycle while no dump is pending and the result side is not stalled, and gives
// its result in the next cycle from a result register; a new event is accepted
// while the previous result is being taken. A fatal exception (NP set) gives
// three store results, and the request side is held off until the dump
// sequencer has had the remaining two stores taken, longer when the result
// side stalls. The *_now fields show the status and save registers after the
// event of the result shown.
`include "cpu_trap_and_interrupt_entry_macros.svh"

module cpu_trap_and_interrupt_entry import trapent_pkg::*; (
  input logic         clk,
  input logic         rst,
  trapent_req_if.sink req,
  trapent_rsp_if.source rsp
);

  // architectural state
  logic [WORD_W-1:0] psw, eipc, eipsw, fepc, fepsw, ecr;
  logic [WORD_W-1:0] psw_next, eipc_next, eipsw_next, fepc_next, fepsw_next, ecr_next;

  // result register
  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [WORD_W-1:0] out_new_pc;
  logic [ADDR_W-1:0] out_store_addr;
  logic [WORD_W-1:0] out_store_data;
  logic              out_last;

  // fatal dump sequencer
  logic [1:0]        beats_left;
  logic [WORD_W-1:0] dump_psw, dump_pc;

  logic              accept, out_fire;
  logic [KIND_W-1:0] res_kind;
  logic [WORD_W-1:0] res_new_pc, res_store_data;
  logic              res_last;
  logic              int_blocked;
  logic [3:0]        level, level_next;
  logic [3:0]        irq_code;

  assign req.ready = (beats_left == 2'd0) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign out_fire  = out_valid && rsp.ready;

  assign level    = psw[PSW_I_HI:PSW_I_LO];
  assign irq_code = req.code[3:0];
  assign int_blocked = psw[PSW_NP] || psw[PSW_EP] || psw[PSW_ID] ||
                       (req.code[CODE_W-1:4] != '0) || (level > irq_code);
  assign level_next  = (irq_code == 4'hF) ? 4'hF : irq_code + 4'd1;

  always_comb begin
    psw_next       = psw;
    eipc_next      = eipc;
    eipsw_next     = eipsw;
    fepc_next      = fepc;
    fepsw_next     = fepsw;
    ecr_next       = ecr;
    res_kind       = KIND_IGNORED;
    res_new_pc     = '0;
    res_store_data = '0;
    res_last       = 1'b1;
    unique case (req.operation)
      OP_INTERRUPT: begin
        if (!int_blocked) begin
          eipc_next  = req.pc;
          eipsw_next = psw;
          ecr_next   = {ecr[WORD_W-1:CODE_W], 16'hFE00 | {8'h00, irq_code, 4'h0}};
          psw_next   = psw;
          psw_next[PSW_EP] = 1'b1;
          psw_next[PSW_ID] = 1'b1;
          psw_next[PSW_AE] = 1'b0;
          psw_next[PSW_I_HI:PSW_I_LO] = level_next;
          res_kind   = KIND_REDIRECT;
          res_new_pc = VEC_INTERRUPT | {24'h0, irq_code, 4'h0};
        end
      end
      OP_EXCEPTION: begin
        if (psw[PSW_NP]) begin
          // first of three dump stores; the rest come from the sequencer
          res_kind       = KIND_FATAL;
          res_store_data = FATAL_TAG | {16'h0, req.code};
          res_last       = 1'b0;
        end else if (psw[PSW_EP]) begin
          fepc_next  = req.pc;
          fepsw_next = psw;
          ecr_next   = {req.code, ecr[CODE_W-1:0]};
          psw_next   = psw;
          psw_next[PSW_NP] = 1'b1;
          psw_next[PSW_ID] = 1'b1;
          psw_next[PSW_AE] = 1'b0;
          res_kind   = KIND_REDIRECT;
          res_new_pc = VEC_DUPLEXED;
        end else begin
          eipc_next  = req.pc;
          eipsw_next = psw;
          ecr_next   = {ecr[WORD_W-1:CODE_W], req.code};
          psw_next   = psw;
          psw_next[PSW_EP] = 1'b1;
          psw_next[PSW_ID] = 1'b1;
          psw_next[PSW_AE] = 1'b0;
          res_kind   = KIND_REDIRECT;
          res_new_pc = VEC_EXCEPTION;
        end
      end
      OP_PSW_WRITE: begin
        psw_next = req.psw_value;
        res_kind = KIND_PSW;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      psw        <= PSW_RESET;
      eipc       <= '0;
      eipsw      <= '0;
      fepc       <= '0;
      fepsw      <= '0;
      ecr        <= '0;
      out_valid  <= 1'b0;
      beats_left <= 2'd0;
    end else begin
      if (accept) begin
        psw        <= psw_next;
        eipc       <= eipc_next;
        eipsw      <= eipsw_next;
        fepc       <= fepc_next;
        fepsw      <= fepsw_next;
        ecr        <= ecr_next;
        out_valid  <= 1'b1;
        beats_left <= (res_kind == KIND_FATAL) ? 2'd2 : 2'd0;
      end else if (out_fire && beats_left != 2'd0) begin
        beats_left <= beats_left - 2'd1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload and dump words
  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind       <= res_kind;
      out_new_pc     <= res_new_pc;
      out_store_addr <= DUMP_ADDR_CODE;
      out_store_data <= res_store_data;
      out_last       <= res_last;
      dump_psw       <= psw;
      dump_pc        <= req.pc;
    end else if (out_fire && beats_left != 2'd0) begin
      out_kind   <= KIND_FATAL;
      out_new_pc <= '0;
      if (beats_left == 2'd2) begin
        out_store_addr <= DUMP_ADDR_PSW;
        out_store_data <= dump_psw;
        out_last       <= 1'b0;
      end else begin
        out_store_addr <= DUMP_ADDR_PC;
        out_store_data <= dump_pc;
        out_last       <= 1'b1;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.kind       = out_kind;
  assign rsp.new_pc     = out_new_pc;
  assign rsp.store_addr = out_store_addr;
  assign rsp.store_data = out_store_data;
  assign rsp.last       = out_last;
  assign rsp.psw_now    = psw;
  assign rsp.eipc_now   = eipc;
  assign rsp.eipsw_now  = eipsw;
  assign rsp.fepc_now   = fepc;
  assign rsp.fepsw_now  = fepsw;
  assign rsp.ecr_now    = ecr;

  `TRAPENT_ASSERT_IMPLIES(a_no_accept_in_dump, clk, rst, beats_left != 2'd0, !req.ready)
  `TRAPENT_ASSERT_NEXT(a_dump_continues, clk, rst, rsp.valid && rsp.ready && rsp.kind == KIND_FATAL && !rsp.last, rsp.valid && rsp.kind == KIND_FATAL)
  `TRAPENT_ASSERT_IMPLIES(a_redirect_sets_ep_or_np, clk, rst, rsp.valid && rsp.kind == KIND_REDIRECT, psw[PSW_EP] || psw[PSW_NP])

endmodule
